FILE: src/rlss_pkg.sv
// Shared types and constants of the random looping step sequencer.
package rlss_pkg;

    localparam int unsigned CmdW  = 2;
    localparam int unsigned ChW   = 4;
    localparam int unsigned MvW   = 15;
    localparam int unsigned RndW  = 61;
    localparam int unsigned StoreW = 16;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 15;

    typedef enum logic [CmdW-1:0] {
        CMD_STEP  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CfgIdxW-1:0] {
        REG_LOCK_GATE = 3'd0,
        REG_LOCK_BOTH = 3'd1,
        REG_LOCK_CV   = 3'd2,
        REG_SRC_BAL   = 3'd3,
        REG_DENSITY   = 3'd4,
        REG_CV_SCALE  = 3'd5,
        REG_CV_OFFSET = 3'd6,
        REG_LOOP_LEN  = 3'd7
    } t_reg;

    localparam logic signed [MvW-1:0] GateHighMv = 15'sd10000;
    localparam logic signed [MvW-1:0] CvMaxMv    = 15'sd12000;
    localparam logic signed [MvW-1:0] CvMinMv    = -15'sd12000;
    localparam logic [13:0] MvFullScale = 14'd10000;

endpackage

FILE: src/rlss_if.sv
// Valid/ready channel interfaces for sequencer items and results.
interface rlss_in_if;
    logic                                valid;
    logic                                ready;
    logic [rlss_pkg::CmdW-1:0]           command;
    logic [rlss_pkg::ChW-1:0]            channel;
    logic signed [rlss_pkg::MvW-1:0]     src_gate_mv;
    logic                                src_gate_present;
    logic signed [rlss_pkg::MvW-1:0]     src_cv_mv;
    logic                                src_cv_present;
    logic                                force_write;
    logic [rlss_pkg::RndW-1:0]           random_bits;
    modport source (output valid, command, channel, src_gate_mv, src_gate_present,
                    src_cv_mv, src_cv_present, force_write, random_bits, input ready);
    modport sink (input valid, command, channel, src_gate_mv, src_gate_present,
                  src_cv_mv, src_cv_present, force_write, random_bits, output ready);
endinterface

interface rlss_out_if;
    logic                                valid;
    logic                                ready;
    logic [rlss_pkg::ChW-1:0]            out_channel;
    logic signed [rlss_pkg::MvW-1:0]     gate_out_mv;
    logic signed [rlss_pkg::MvW-1:0]     cv_out_mv;
    modport source (output valid, out_channel, gate_out_mv, cv_out_mv, input ready);
    modport sink (input valid, out_channel, gate_out_mv, cv_out_mv, output ready);
endinterface

FILE: src/random_looping_step_sequencer.sv
// Top level of the random looping step sequencer.
//
//  channel  direction  what it carries
//  i_item   in         command, channel, source gate/cv, force, random word
//  o_step   out        channel, gate and cv of the step played
//  cfg      in         write enable, register index, write data
//
// Shift and clear commands are taken in the idle state and give no word. A
// step is taken into S_HEAD, walks the loop entries in S_CLR_G/S_CLR_C when
// a clear is pending, adds or takes off the loop length in S_MOD until head +
// shift lies in range, then passes S_RD_G, S_RD_C, S_DRAW, S_MUL1, S_MUL2,
// S_CVSUM, S_WR and S_OUT, using the single RAM port and the shared adder; the
// next item is taken only after S_OUT. After reset a clearing pass over every
// memory entry (CHANNELS*MAX_STEPS at the default sizes) zeroes the loop
// memories; no item is taken meanwhile. A result waits in its output register;
// the next item is taken only once it has gone.
module random_looping_step_sequencer #(
    parameter int unsigned CHANNELS      = 16,
    parameter int unsigned MAX_STEPS     = 32,
    parameter int unsigned FRACTION_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlss_in_if.sink                         i_item,
    rlss_out_if.source                      o_step,
    input  logic                            i_cfg_we,
    input  logic [rlss_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [rlss_pkg::CfgDataW-1:0]   i_cfg_data
);
    localparam int unsigned StepW  = $clog2(MAX_STEPS);
    localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned AddrW  = ChIdxW + StepW;
    localparam int unsigned Depth  = 1 << AddrW;
    localparam int unsigned LenW   = StepW + 1;
    localparam int unsigned FracShift = 10 - FRACTION_BITS;

    typedef enum logic [13:0] {
        S_CLR_INIT = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_CLR_G    = 14'b00000000000100,
        S_CLR_C    = 14'b00000000001000,
        S_HEAD     = 14'b00000000010000,
        S_MOD      = 14'b00000000100000,
        S_RD_G     = 14'b00000001000000,
        S_RD_C     = 14'b00000010000000,
        S_DRAW     = 14'b00000100000000,
        S_MUL1     = 14'b00001000000000,
        S_MUL2     = 14'b00010000000000,
        S_CVSUM    = 14'b00100000000000,
        S_WR       = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [6:0]  r_lock_gate, r_lock_cv, r_src_bal, r_density;
    logic [7:0]  r_lock_both;
    logic [11:0] r_cv_scale;
    logic [14:0] r_cv_offset;
    logic [5:0]  r_loop_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_gate <= '0; r_lock_both <= '0; r_lock_cv <= '0;
            r_src_bal <= 7'd100; r_density <= 7'd50;
            r_cv_scale <= 12'd1024; r_cv_offset <= '0; r_loop_len <= 6'd16;
        end else if (i_cfg_we) begin
            unique case (rlss_pkg::t_reg'(i_cfg_idx))
                rlss_pkg::REG_LOCK_GATE: r_lock_gate <= i_cfg_data[6:0];
                rlss_pkg::REG_LOCK_BOTH: r_lock_both <= i_cfg_data[7:0];
                rlss_pkg::REG_LOCK_CV:   r_lock_cv   <= i_cfg_data[6:0];
                rlss_pkg::REG_SRC_BAL:   r_src_bal   <= i_cfg_data[6:0];
                rlss_pkg::REG_DENSITY:   r_density   <= i_cfg_data[6:0];
                rlss_pkg::REG_CV_SCALE:  r_cv_scale  <= i_cfg_data[11:0];
                rlss_pkg::REG_CV_OFFSET: r_cv_offset <= i_cfg_data;
                rlss_pkg::REG_LOOP_LEN:  r_loop_len  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // clamped loop length
    logic [LenW-1:0] len;
    always_comb begin
        if (r_loop_len == '0)
            len = LenW'(1);
        else if (32'(r_loop_len) > MAX_STEPS)
            len = LenW'(MAX_STEPS);
        else
            len = LenW'(r_loop_len);
    end

    // per-channel control state
    logic [StepW-1:0]  r_head [CHANNELS];
    logic signed [5:0] r_shift [CHANNELS];
    logic [CHANNELS-1:0] r_clr;

    // latched item
    logic [ChIdxW-1:0]         r_ch;
    logic [rlss_pkg::ChW-1:0]  r_ch_full;
    logic signed [14:0]        r_src_gate, r_src_cv;
    logic                      r_gate_pres, r_cv_pres, r_force;
    logic [rlss_pkg::RndW-1:0] r_rnd;

    // loop memory: gate and cv in one word, single port
    logic [2*rlss_pkg::StoreW-1:0] r_mem [Depth];
    logic [2*rlss_pkg::StoreW-1:0] r_rdata;
    logic [AddrW-1:0]  mem_addr;
    logic              mem_we;
    logic [2*rlss_pkg::StoreW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rdata <= r_mem[mem_addr];
    end

    // working registers
    logic [AddrW:0]      r_cnt;      // clearing pass / clear walk counter
    logic signed [17:0]  r_hsum;     // head + shift, reduced by len
    logic [StepW-1:0]    r_h;
    logic signed [15:0]  r_gate, r_cv;
    logic                r_g_rep, r_c_rep, r_g_rnd, r_c_rnd;
    logic [23:0]         r_prod;     // f * |scale|
    logic [37:0]         r_prod2;    // * 10000
    logic [rlss_pkg::ChW-1:0] r_o_ch;
    logic signed [14:0]  r_o_gate, r_o_cv;
    logic                r_o_valid;

    function automatic logic [9:0] frac(input logic [60:0] b, input int unsigned s);
        logic [9:0] raw;
        raw = b[10*s +: 10];
        return raw >> FracShift;
    endfunction

    // f*100 > pct * 2^FB
    function automatic logic above(input logic [9:0] f, input logic signed [9:0] pct);
        logic signed [19:0] lhs, rhs;
        lhs = 20'(f) * 20'sd100;
        rhs = 20'(pct) <<< FRACTION_BITS;
        return lhs > rhs;
    endfunction

    logic signed [9:0] both_s;
    assign both_s = 10'(signed'(r_lock_both));

    logic shared_store_path;
    assign shared_store_path = 1'b1;

    logic [AddrW-1:0] head_addr;
    assign head_addr = {r_ch, r_h};

    // one shared adder for head arithmetic / cv sum
    logic signed [17:0] add_a, add_b, add_y;
    assign add_y = add_a + add_b;

    logic signed [17:0] mag_s;
    logic [11:0] abs_scale;
    assign abs_scale = r_cv_scale[11] ? 12'(-r_cv_scale) : r_cv_scale;
    assign mag_s = 18'(r_prod2 >> (FRACTION_BITS + 10));

    always_comb begin
        add_a = '0;
        add_b = '0;
        if (r_state == S_HEAD) begin
            add_a = 18'(r_head[r_ch]);
            add_b = 18'(r_shift[r_ch]);
        end else if (r_state == S_MOD) begin
            add_a = r_hsum;
            add_b = (r_hsum < 0) ? 18'(len) : -18'(len);
        end else begin
            add_a = (r_cv_scale[11] && !r_rnd[60]) ? -mag_s : mag_s;
            add_b = 18'(signed'(r_cv_offset));
        end
    end

    logic accept;
    assign i_item.ready = (r_state == S_IDLE) && !r_o_valid;
    assign accept = i_item.valid && i_item.ready;

    always_comb begin
        mem_addr = head_addr;
        mem_we = 1'b0;
        mem_wdata = {r_gate, r_cv};
        unique case (r_state)
            S_CLR_INIT: begin
                mem_addr = r_cnt[AddrW-1:0];
                mem_we = 1'b1;
                mem_wdata = '0;
            end
            S_CLR_G: begin
                mem_addr = {r_ch, r_cnt[StepW-1:0]};
                mem_we = 1'b1;
                mem_wdata = '0;
            end
            S_WR: mem_we = r_g_rep || r_c_rep;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR_INIT: if (r_cnt == (AddrW+1)'(Depth - 1)) n_state = S_IDLE;
            S_IDLE: if (accept && 32'(i_item.channel) < CHANNELS
                        && rlss_pkg::t_cmd'(i_item.command) == rlss_pkg::CMD_STEP)
                        n_state = S_HEAD;
            S_HEAD:  n_state = r_clr[r_ch] ? S_CLR_G : S_MOD;
            S_CLR_G: n_state = S_CLR_C;
            S_CLR_C: n_state = ((r_cnt[LenW-1:0] + LenW'(1)) >= len) ? S_HEAD : S_CLR_G;
            S_MOD:   n_state = (r_hsum >= 0 && r_hsum < signed'(18'(len))) ? S_RD_G : S_MOD;
            S_RD_G:  n_state = S_RD_C;
            S_RD_C:  n_state = S_DRAW;
            S_DRAW:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_CVSUM;
            S_CVSUM: n_state = S_WR;
            S_WR:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [9:0] f0, f1, f2, f3, f4, f5;
    assign f0 = frac(r_rnd, 0);
    assign f1 = frac(r_rnd, 1);
    assign f2 = frac(r_rnd, 2);
    assign f3 = frac(r_rnd, 3);
    assign f4 = frac(r_rnd, 4);
    assign f5 = frac(r_rnd, 5);

    logic signed [17:0] cv_sat16;
    always_comb begin
        if (add_y > 18'sd32767) cv_sat16 = 18'sd32767;
        else if (add_y < -18'sd32768) cv_sat16 = -18'sd32768;
        else cv_sat16 = add_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
            r_cnt <= '0;
            r_clr <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_head[i] <= '0;
                r_shift[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_step.valid && o_step.ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_CLR_INIT: r_cnt <= r_cnt + 1'b1;
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept && 32'(i_item.channel) < CHANNELS) begin
                        r_ch <= ChIdxW'(i_item.channel);
                        r_ch_full <= i_item.channel;
                        r_src_gate <= i_item.src_gate_mv;
                        r_src_cv <= i_item.src_cv_mv;
                        r_gate_pres <= i_item.src_gate_present;
                        r_cv_pres <= i_item.src_cv_present;
                        r_force <= i_item.force_write;
                        r_rnd <= i_item.random_bits;
                        unique case (rlss_pkg::t_cmd'(i_item.command))
                            rlss_pkg::CMD_LEFT:
                                if (r_shift[ChIdxW'(i_item.channel)] > -6'sd32)
                                    r_shift[ChIdxW'(i_item.channel)] <=
                                        r_shift[ChIdxW'(i_item.channel)] - 6'sd1;
                            rlss_pkg::CMD_RIGHT:
                                if (r_shift[ChIdxW'(i_item.channel)] < 6'sd31)
                                    r_shift[ChIdxW'(i_item.channel)] <=
                                        r_shift[ChIdxW'(i_item.channel)] + 6'sd1;
                            rlss_pkg::CMD_CLEAR: r_clr[ChIdxW'(i_item.channel)] <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_HEAD: begin
                    if (r_clr[r_ch]) begin
                        r_head[r_ch] <= '0;
                        r_shift[r_ch] <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_hsum <= add_y;
                        r_shift[r_ch] <= '0;
                    end
                end
                S_CLR_C: begin
                    r_cnt <= r_cnt + 1'b1;
                    if ((r_cnt[LenW-1:0] + LenW'(1)) >= len) r_clr[r_ch] <= 1'b0;
                end
                S_MOD: begin
                    // subtract or add len until the head lies in range
                    if (r_hsum >= 0 && r_hsum < signed'(18'(len))) r_h <= StepW'(r_hsum);
                    else r_hsum <= add_y;
                end
                S_RD_C: begin
                    r_gate <= signed'(r_rdata[31:16]);
                    r_cv <= signed'(r_rdata[15:0]);
                end
                S_DRAW: begin
                    r_g_rep <= above(f0, 10'(r_lock_gate) + both_s) || r_force;
                    r_c_rep <= above(f3, 10'(r_lock_cv) + both_s) || r_force;
                    r_g_rnd <= !((above(f1, 10'(r_src_bal)) || r_force) && r_gate_pres);
                    r_c_rnd <= !((above(f4, 10'(r_src_bal)) || r_force) && r_cv_pres);
                    r_prod <= 24'(f5) * 24'(abs_scale);
                end
                S_MUL1: r_prod2 <= 38'(r_prod) * 38'(rlss_pkg::MvFullScale);
                S_MUL2: begin
                    if (r_g_rep) begin
                        if (!r_g_rnd) r_gate <= 16'(r_src_gate);
                        else if (above(f2, 10'(r_density))) r_gate <= '0;
                        else r_gate <= 16'(rlss_pkg::GateHighMv);
                    end
                end
                S_CVSUM: begin
                    if (r_c_rep) begin
                        if (!r_c_rnd) r_cv <= 16'(r_src_cv);
                        else r_cv <= 16'(cv_sat16);
                    end
                end
                S_WR: begin
                    r_o_ch <= r_ch_full;
                    r_o_gate <= 15'(r_gate);
                    if (r_cv > 16'(rlss_pkg::CvMaxMv)) r_o_cv <= rlss_pkg::CvMaxMv;
                    else if (r_cv < 16'(rlss_pkg::CvMinMv)) r_o_cv <= rlss_pkg::CvMinMv;
                    else r_o_cv <= 15'(r_cv);
                end
                S_OUT: begin
                    r_o_valid <= shared_store_path;
                    r_head[r_ch] <= (LenW'(r_h) + LenW'(1) >= len) ? '0 : r_h + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_step.valid = r_o_valid;
    assign o_step.out_channel = r_o_ch;
    assign o_step.gate_out_mv = r_o_gate;
    assign o_step.cv_out_mv = r_o_cv;

endmodule

FILE: verif/tb_random_looping_step_sequencer.sv
// Self-checking testbench for the random looping step sequencer.
`timescale 1ns / 1ps

module tb_random_looping_step_sequencer;

    localparam int unsigned NumCh      = 16;
    localparam int unsigned NumSteps   = 32;
    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned RandomPerPhase = 180;

    typedef struct packed {
        logic [rlss_pkg::ChW-1:0]        channel;
        logic signed [rlss_pkg::MvW-1:0] gate_mv;
        logic signed [rlss_pkg::MvW-1:0] cv_mv;
    } t_step_word;

    typedef struct {
        rlss_pkg::t_cmd                  command;
        logic [rlss_pkg::ChW-1:0]        channel;
        logic signed [rlss_pkg::MvW-1:0] src_gate;
        logic                            gate_present;
        logic signed [rlss_pkg::MvW-1:0] src_cv;
        logic                            cv_present;
        logic                            force_wr;
        logic [rlss_pkg::RndW-1:0]       rnd;
        bit                              typed;
        logic signed [rlss_pkg::MvW-1:0] typed_gate;
        logic signed [rlss_pkg::MvW-1:0] typed_cv;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rlss_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [rlss_pkg::CfgDataW-1:0] i_cfg_data;

    rlss_in_if  item_ch ();
    rlss_out_if step_ch ();

    random_looping_step_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_step     (step_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the sequencer state and registers
    logic [6:0]  lock_gate, lock_cv, src_bal, density;
    logic [7:0]  lock_both;
    logic [11:0] cv_scale;
    logic [14:0] cv_offset;
    logic [5:0]  loop_len;
    logic signed [rlss_pkg::StoreW-1:0] gate_loop [NumCh*NumSteps];
    logic signed [rlss_pkg::StoreW-1:0] cv_loop   [NumCh*NumSteps];
    int head_pos [NumCh];
    int shift_due [NumCh];
    bit clear_due [NumCh];

    t_step_word expected_steps [$];
    int unsigned err_count = 0, steps_seen = 0, shifts_taken = 0, clears_taken = 0;
    int unsigned words_taken = 0, cycles = 0;
    int send_idle, recv_idle;
    bit held_once = 0;
    int hold_left = 0;
    logic cur_typed;
    logic signed [rlss_pkg::MvW-1:0] cur_typed_gate, cur_typed_cv;

    always #10 i_clk = ~i_clk;

    function automatic bit draw_above(logic [9:0] f, int pct);
        return longint'(f) * 100 > longint'(pct) * 1024;
    endfunction

    function automatic void reset_model();
        lock_gate = 0; lock_both = 0; lock_cv = 0; src_bal = 100;
        density = 50; cv_scale = 12'd1024; cv_offset = 0; loop_len = 16;
        foreach (gate_loop[i]) begin
            gate_loop[i] = 0;
            cv_loop[i] = 0;
        end
        foreach (head_pos[i]) begin
            head_pos[i] = 0;
            shift_due[i] = 0;
            clear_due[i] = 0;
        end
    endfunction

    function automatic void model_reg(rlss_pkg::t_reg idx, logic [rlss_pkg::CfgDataW-1:0] v);
        case (idx)
            rlss_pkg::REG_LOCK_GATE: lock_gate = v[6:0];
            rlss_pkg::REG_LOCK_BOTH: lock_both = v[7:0];
            rlss_pkg::REG_LOCK_CV:   lock_cv = v[6:0];
            rlss_pkg::REG_SRC_BAL:   src_bal = v[6:0];
            rlss_pkg::REG_DENSITY:   density = v[6:0];
            rlss_pkg::REG_CV_SCALE:  cv_scale = v[11:0];
            rlss_pkg::REG_CV_OFFSET: cv_offset = v[14:0];
            rlss_pkg::REG_LOOP_LEN:  loop_len = v[5:0];
            default: ;
        endcase
    endfunction

    // Apply one accepted word; returns 1 and the step when a step is played
    function automatic bit play_word(rlss_pkg::t_cmd cmd, int ch,
                                     logic signed [rlss_pkg::MvW-1:0] sg, logic sgp,
                                     logic signed [rlss_pkg::MvW-1:0] scv, logic scvp,
                                     logic fw, logic [rlss_pkg::RndW-1:0] rnd,
                                     output t_step_word res);
        int len, base, h, both, gate, cvv, scale;
        longint mag, v;
        res = '0;
        case (cmd)
            rlss_pkg::CMD_LEFT: begin
                if (shift_due[ch] > -32) shift_due[ch]--;
                return 0;
            end
            rlss_pkg::CMD_RIGHT: begin
                if (shift_due[ch] < 31) shift_due[ch]++;
                return 0;
            end
            rlss_pkg::CMD_CLEAR: begin
                clear_due[ch] = 1;
                return 0;
            end
            default: ;
        endcase
        len = loop_len;
        if (len < 1) len = 1;
        if (len > NumSteps) len = NumSteps;
        base = ch * NumSteps;
        if (clear_due[ch]) begin
            for (int i = 0; i < len; i++) begin
                gate_loop[base+i] = 0;
                cv_loop[base+i] = 0;
            end
            head_pos[ch] = 0;
            shift_due[ch] = 0;
            clear_due[ch] = 0;
        end
        h = (head_pos[ch] + shift_due[ch]) % len;
        if (h < 0) h += len;
        shift_due[ch] = 0;
        gate = gate_loop[base+h];
        cvv = cv_loop[base+h];
        both = int'(signed'(lock_both));
        if (draw_above(rnd[9:0], int'(lock_gate) + both) || fw) begin
            if ((draw_above(rnd[19:10], int'(src_bal)) || fw) && sgp)
                gate = sg;
            else
                gate = draw_above(rnd[29:20], int'(density)) ? 0
                                                             : int'(rlss_pkg::GateHighMv);
            gate_loop[base+h] = gate[rlss_pkg::StoreW-1:0];
        end
        if (draw_above(rnd[39:30], int'(lock_cv) + both) || fw) begin
            if ((draw_above(rnd[49:40], int'(src_bal)) || fw) && scvp) begin
                cvv = scv;
            end else begin
                scale = int'(signed'(cv_scale));
                mag = scale < 0 ? -longint'(scale) : longint'(scale);
                mag = (longint'(rnd[59:50]) * mag * 10000) >>> 20;
                if (scale < 0 && !rnd[60]) mag = -mag;
                v = mag + longint'(signed'(cv_offset));
                if (v < -32768) v = -32768;
                if (v > 32767) v = 32767;
                cvv = int'(v);
            end
            cv_loop[base+h] = cvv[rlss_pkg::StoreW-1:0];
        end
        if (cvv > int'(rlss_pkg::CvMaxMv)) cvv = rlss_pkg::CvMaxMv;
        if (cvv < int'(rlss_pkg::CvMinMv)) cvv = rlss_pkg::CvMinMv;
        res.channel = ch[rlss_pkg::ChW-1:0];
        res.gate_mv = gate[rlss_pkg::MvW-1:0];
        res.cv_mv = cvv[rlss_pkg::MvW-1:0];
        head_pos[ch] = (h + 1) % len;
        return 1;
    endfunction

    // Predict on each accepted item, check each accepted step
    always @(posedge i_clk) begin
        t_step_word want, got;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            words_taken++;
            if (rlss_pkg::t_cmd'(item_ch.command) == rlss_pkg::CMD_LEFT
                || rlss_pkg::t_cmd'(item_ch.command) == rlss_pkg::CMD_RIGHT)
                shifts_taken++;
            if (rlss_pkg::t_cmd'(item_ch.command) == rlss_pkg::CMD_CLEAR) clears_taken++;
            if (play_word(rlss_pkg::t_cmd'(item_ch.command), item_ch.channel,
                          item_ch.src_gate_mv, item_ch.src_gate_present, item_ch.src_cv_mv,
                          item_ch.src_cv_present, item_ch.force_write,
                          item_ch.random_bits, want)) begin
                if (cur_typed) begin
                    want.gate_mv = cur_typed_gate;
                    want.cv_mv = cur_typed_cv;
                end
                expected_steps.push_back(want);
            end
        end
        if (i_rst_n && step_ch.valid && step_ch.ready) begin
            steps_seen++;
            got.channel = step_ch.out_channel;
            got.gate_mv = step_ch.gate_out_mv;
            got.cv_mv = step_ch.cv_out_mv;
            if (expected_steps.size() == 0) begin
                $error("step word with none expected: channel %0d", got.channel);
                err_count++;
            end else begin
                want = expected_steps.pop_front();
                if (got.channel !== want.channel) begin
                    $error("out_channel: expected %0d, got %0d", want.channel, got.channel);
                    err_count++;
                end
                if (got.gate_mv !== want.gate_mv) begin
                    $error("gate_out_mv: expected %0d, got %0d", want.gate_mv, got.gate_mv);
                    err_count++;
                end
                if (got.cv_mv !== want.cv_mv) begin
                    $error("cv_out_mv: expected %0d, got %0d", want.cv_mv, got.cv_mv);
                    err_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            step_ch.ready <= 0;
        end else if (!held_once && words_taken >= 200) begin
            held_once <= 1;
            hold_left <= 400;
            step_ch.ready <= 0;
        end else begin
            step_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL random_looping_step_sequencer");
            $finish;
        end
    end

    task automatic write_reg(rlss_pkg::t_reg idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[rlss_pkg::CfgDataW-1:0];
        model_reg(idx, value[rlss_pkg::CfgDataW-1:0]);
    endtask

    task automatic write_all(int lg, int lb, int lc, int sb, int dn, int sc, int off, int ln);
        write_reg(rlss_pkg::REG_LOCK_GATE, lg);
        write_reg(rlss_pkg::REG_LOCK_BOTH, lb);
        write_reg(rlss_pkg::REG_LOCK_CV, lc);
        write_reg(rlss_pkg::REG_SRC_BAL, sb);
        write_reg(rlss_pkg::REG_DENSITY, dn);
        write_reg(rlss_pkg::REG_CV_SCALE, sc);
        write_reg(rlss_pkg::REG_CV_OFFSET, off);
        write_reg(rlss_pkg::REG_LOOP_LEN, ln);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Drive one word and hold it until taken
    task automatic send_word(t_row r);
        if ($urandom_range(99) < send_idle) begin
            item_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        item_ch.valid <= 1;
        item_ch.command <= r.command;
        item_ch.channel <= r.channel;
        item_ch.src_gate_mv <= r.src_gate;
        item_ch.src_gate_present <= r.gate_present;
        item_ch.src_cv_mv <= r.src_cv;
        item_ch.src_cv_present <= r.cv_present;
        item_ch.force_write <= r.force_wr;
        item_ch.random_bits <= r.rnd;
        cur_typed <= r.typed;
        cur_typed_gate <= r.typed_gate;
        cur_typed_cv <= r.typed_cv;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
    endtask

    task automatic drain();
        item_ch.valid <= 0;
        wait (expected_steps.size() == 0);
        // shifts and clears give no word; let the last one finish
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_row mk(rlss_pkg::t_cmd c, int ch, int sg, bit sgp, int scv, bit scvp,
                                bit fw, logic [rlss_pkg::RndW-1:0] rnd, bit typed = 0,
                                int tg = 0, int tc = 0);
        t_row r;
        r.command = c; r.channel = ch[rlss_pkg::ChW-1:0];
        r.src_gate = sg[rlss_pkg::MvW-1:0]; r.gate_present = sgp;
        r.src_cv = scv[rlss_pkg::MvW-1:0]; r.cv_present = scvp;
        r.force_wr = fw; r.rnd = rnd;
        r.typed = typed;
        r.typed_gate = tg[rlss_pkg::MvW-1:0];
        r.typed_cv = tc[rlss_pkg::MvW-1:0];
        return r;
    endfunction

    function automatic t_row random_row();
        t_row r;
        int pick;
        logic [63:0] raw;
        pick = $urandom_range(99);
        raw = {$urandom, $urandom};
        r = mk(rlss_pkg::CMD_STEP, $urandom_range(NumCh-1), $urandom, $urandom_range(1),
               $urandom, $urandom_range(1), $urandom_range(9) == 0,
               raw[rlss_pkg::RndW-1:0]);
        if (pick >= 90) r.command = rlss_pkg::CMD_CLEAR;
        else if (pick >= 75) r.command = rlss_pkg::CMD_RIGHT;
        else if (pick >= 60) r.command = rlss_pkg::CMD_LEFT;
        return r;
    endfunction

    initial begin
        t_row dir_rows [$];
        t_row r;
        int ch;
        logic [rlss_pkg::RndW-1:0] ones;
        logic [63:0] raw64;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        item_ch.valid = 0;
        item_ch.command = rlss_pkg::CMD_STEP;
        item_ch.channel = '0;
        item_ch.src_gate_mv = '0;
        item_ch.src_gate_present = 0;
        item_ch.src_cv_mv = '0;
        item_ch.src_cv_present = 0;
        item_ch.force_write = 0;
        item_ch.random_bits = '0;
        cur_typed = 0;
        cur_typed_gate = '0;
        cur_typed_cv = '0;
        send_idle = 20; recv_idle = 74;
        ones = '1;
        raw64 = {$urandom, $urandom};
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: reset contents, extremes, every command, clear and shift wrap
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, '0, 1, 0, 0));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 15, 12000, 1, -12000, 1, 1, '0,
                              1, 12000, -12000));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 1, -12000, 1, 12000, 1, 1, ones,
                              1, -12000, 12000));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 2, 16383, 1, 16383, 1, 1, '0,
                              1, 16383, 12000));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 3, -16384, 1, -16384, 1, 1, '0,
                              1, -16384, -12000));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 4, 5, 0, 5, 0, 1, ones, 1, 0, 9990));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 4, 7, 1, 7, 1, 0, ones));
        dir_rows.push_back(mk(rlss_pkg::CMD_LEFT, 5, 0, 0, 0, 0, 0, ones));
        dir_rows.push_back(mk(rlss_pkg::CMD_RIGHT, 5, 0, 0, 0, 0, 0, ones));
        dir_rows.push_back(mk(rlss_pkg::CMD_RIGHT, 5, 0, 0, 0, 0, 0, ones));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 5, 300, 1, 400, 1, 1, ones));
        dir_rows.push_back(mk(rlss_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, '0, 1, 0, 0));
        dir_rows.push_back(mk(rlss_pkg::CMD_LEFT, 15, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 15, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk(rlss_pkg::CMD_LEFT, 1, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk(rlss_pkg::CMD_LEFT, 1, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 1, 0, 0, 0, 0, 0, '0));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 6, 1234, 1, -777, 1, 0,
                              raw64[rlss_pkg::RndW-1:0]));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 7, 0, 1, 0, 1, 0, 61'h0AAA_AAAA_AAAA_AAAA));
        dir_rows.push_back(mk(rlss_pkg::CMD_STEP, 8, 0, 1, 0, 1, 0, 61'h1555_5555_5555_5555));
        foreach (dir_rows[i]) send_word(dir_rows[i]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_all(100, 100, 100, 100, 100, 1024, 10000, 32);
                1: write_all(0, -100, 0, 0, 0, -1024, -10000, 1);
                2: write_all(127, 127, 127, 127, 127, -2048, -16384, 0);
                3: write_all($urandom_range(100), $urandom_range(200) - 100,
                             $urandom_range(100), $urandom_range(100), $urandom_range(100),
                             $urandom_range(2048) - 1024, $urandom_range(20000) - 10000, 63);
                4: write_all(30, -20, 40, 50, 50, -700, 2500, 5);
                default: write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom_range(1, 32));
            endcase
            case (phase)
                0, 1: begin send_idle = 20; recv_idle = 74; end
                2, 3: begin send_idle = 74; recv_idle = 20; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int n = 0; n < RandomPerPhase; n++) begin
                if ($urandom_range(49) == 0) begin
                    // run a shift past its saturation point, then play it
                    ch = $urandom_range(NumCh-1);
                    r = mk($urandom_range(1) ? rlss_pkg::CMD_LEFT : rlss_pkg::CMD_RIGHT,
                           ch, 0, 0, 0, 0, 0, '0);
                    repeat (34 + $urandom_range(6)) send_word(r);
                    r = random_row();
                    r.command = rlss_pkg::CMD_STEP;
                    r.channel = ch[rlss_pkg::ChW-1:0];
                    send_word(r);
                end else begin
                    send_word(random_row());
                end
            end
            drain();
        end

        $display("Ran %0d words (%0d shifts, %0d clears) over six register settings,",
                 words_taken, shifts_taken, clears_taken);
        $display("checked %0d step words with stalls on both sides.", steps_seen);
        if (err_count == 0 && expected_steps.size() == 0) begin
            $display("PASS random_looping_step_sequencer");
        end else begin
            $display("FAIL random_looping_step_sequencer");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/rlss_pkg.sv
src/rlss_if.sv
src/random_looping_step_sequencer.sv
verif/tb_random_looping_step_sequencer.sv
